### hdl/m3i_pkg.sv
`default_nettype none

package m3i_pkg;

   localparam int N_ENT   = 9;
   localparam int ENTRY_W = 32;
   localparam int PROD_W  = 2 * ENTRY_W;
   localparam int COF_W   = PROD_W + 1;
   localparam int PART_W  = ENTRY_W + 33;
   localparam int DET_W   = 98;
   localparam int DMAG_W  = 96;
   localparam int CMAG_W  = 64;
   localparam int QUO_W   = 32;
   localparam int REM_W   = DMAG_W + QUO_W + 1;

   typedef logic [3:0] idx_type;

   // entry pairs per cofactor: m[0]*m[1] - m[2]*m[3]
   localparam idx_type COF_IDX [N_ENT][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   // cofactors of row 0 for the determinant expansion
   localparam idx_type DET_COF [3] = '{4'd0, 4'd3, 4'd6};

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             ovf;
   } div_lane_type;

   typedef struct packed {
      logic [DMAG_W-1:0]              dmag;
      logic                           singular;
      div_lane_type [N_ENT-1:0]       lane;
   } div_word_type;

endpackage

`default_nettype wire

### hdl/matrix3x3_inverse.sv
`default_nettype none

// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_a00 .. req_a22 (signed q16.16)
// rsp      out        rsp_valid/rsp_stall  rsp_inv00 .. rsp_inv22, singular, overflow
//
// one word enters per cycle unless a held result stalls the pipeline
// 7 stages of products, cofactors and determinant, 33 divider stages
// (an overflow check, then one quotient bit per stage for each of the nine lanes), one output stage
// reset is synchronous and clears only the valid bits
// a stalled result freezes the whole pipeline; nothing is dropped or repeated

module matrix3x3_inverse
   import m3i_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [ENTRY_W-1:0] req_a00,
   input  wire logic signed [ENTRY_W-1:0] req_a01,
   input  wire logic signed [ENTRY_W-1:0] req_a02,
   input  wire logic signed [ENTRY_W-1:0] req_a10,
   input  wire logic signed [ENTRY_W-1:0] req_a11,
   input  wire logic signed [ENTRY_W-1:0] req_a12,
   input  wire logic signed [ENTRY_W-1:0] req_a20,
   input  wire logic signed [ENTRY_W-1:0] req_a21,
   input  wire logic signed [ENTRY_W-1:0] req_a22,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [ENTRY_W-1:0]      rsp_inv00,
   output logic signed [ENTRY_W-1:0]      rsp_inv01,
   output logic signed [ENTRY_W-1:0]      rsp_inv02,
   output logic signed [ENTRY_W-1:0]      rsp_inv10,
   output logic signed [ENTRY_W-1:0]      rsp_inv11,
   output logic signed [ENTRY_W-1:0]      rsp_inv12,
   output logic signed [ENTRY_W-1:0]      rsp_inv20,
   output logic signed [ENTRY_W-1:0]      rsp_inv21,
   output logic signed [ENTRY_W-1:0]      rsp_inv22,
   output logic                           rsp_singular,
   output logic                           rsp_overflow
);

   localparam int FRONT = 7;

   // pipeline advances unless a finished word is held by the receiver
   logic rsp_valid_ff;
   logic enable;
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   logic [FRONT-1:0] vld_ff;

   // stage a: input capture
   logic signed [ENTRY_W-1:0] mat_in [N_ENT];
   logic signed [ENTRY_W-1:0] mat_ff [N_ENT];

   assign mat_in[0] = req_a00;
   assign mat_in[1] = req_a01;
   assign mat_in[2] = req_a02;
   assign mat_in[3] = req_a10;
   assign mat_in[4] = req_a11;
   assign mat_in[5] = req_a12;
   assign mat_in[6] = req_a20;
   assign mat_in[7] = req_a21;
   assign mat_in[8] = req_a22;

   // stage b: the eighteen entry products
   logic signed [PROD_W-1:0]  prod_in [2*N_ENT];
   logic signed [PROD_W-1:0]  prod_ff [2*N_ENT];
   logic signed [ENTRY_W-1:0] row_b_ff [3];

   always_comb begin
      for (int k = 0; k < N_ENT; k++) begin
         prod_in[2*k]   = PROD_W'(mat_ff[COF_IDX[k][0]]) * PROD_W'(mat_ff[COF_IDX[k][1]]);
         prod_in[2*k+1] = PROD_W'(mat_ff[COF_IDX[k][2]]) * PROD_W'(mat_ff[COF_IDX[k][3]]);
      end
   end

   // stage c: cofactors, exact
   logic signed [COF_W-1:0]   cof_in [N_ENT];
   logic signed [COF_W-1:0]   cof_ff [N_ENT];
   logic signed [ENTRY_W-1:0] row_c_ff [3];

   always_comb begin
      for (int k = 0; k < N_ENT; k++) begin
         cof_in[k] = COF_W'(prod_ff[2*k]) - COF_W'(prod_ff[2*k+1]);
      end
   end

   // stage d: row 0 times its cofactors, each cofactor split at bit 32 into two partial products
   logic signed [PART_W-1:0] part_lo_in [3];
   logic signed [PART_W-1:0] part_hi_in [3];
   logic signed [PART_W-1:0] part_lo_ff [3];
   logic signed [PART_W-1:0] part_hi_ff [3];
   logic signed [COF_W-1:0]  cof_d_ff [N_ENT];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         part_lo_in[i] = PART_W'(row_c_ff[i])
                       * PART_W'($signed({1'b0, cof_ff[DET_COF[i]][31:0]}));
         part_hi_in[i] = PART_W'(row_c_ff[i])
                       * PART_W'($signed(cof_ff[DET_COF[i]][COF_W-1:32]));
      end
   end

   // stage e: recombine partial products
   logic signed [DET_W-1:0] term_in [3];
   logic signed [DET_W-1:0] term_ff [3];
   logic signed [COF_W-1:0] cof_e_ff [N_ENT];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         term_in[i] = (DET_W'(part_hi_ff[i]) <<< 32) + DET_W'(part_lo_ff[i]);
      end
   end

   // stage f: determinant
   logic signed [DET_W-1:0] det_in;
   logic signed [DET_W-1:0] det_ff;
   logic signed [COF_W-1:0] cof_f_ff [N_ENT];

   assign det_in = term_ff[0] + term_ff[1] + term_ff[2];

   // stage g: magnitudes, signs and scaled numerators for the divider
   div_word_type            div_in;
   div_word_type            div_in_ff;
   logic                    dneg;
   logic [DET_W-1:0]        dabs;
   logic [N_ENT-1:0]        cneg;
   logic [COF_W-1:0]        cabs [N_ENT];

   always_comb begin
      dneg            = det_ff[DET_W-1];
      dabs            = dneg ? -det_ff : det_ff;
      div_in.dmag     = dabs[DMAG_W-1:0];
      div_in.singular = det_ff == '0;
      for (int l = 0; l < N_ENT; l++) begin
         cneg[l]            = cof_f_ff[l][COF_W-1];
         cabs[l]            = cneg[l] ? -cof_f_ff[l] : cof_f_ff[l];
         div_in.lane[l].rem = REM_W'(cabs[l][CMAG_W-1:0]) << (2 * FRAC_BITS);
         div_in.lane[l].quo = '0;
         div_in.lane[l].neg = cneg[l] ^ dneg;
         div_in.lane[l].ovf = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[FRONT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mat_ff     <= mat_in;
         prod_ff    <= prod_in;
         row_b_ff   <= mat_ff[0:2];
         cof_ff     <= cof_in;
         row_c_ff   <= row_b_ff;
         part_lo_ff <= part_lo_in;
         part_hi_ff <= part_hi_in;
         cof_d_ff   <= cof_ff;
         term_ff    <= term_in;
         cof_e_ff   <= cof_d_ff;
         det_ff     <= det_in;
         cof_f_ff   <= cof_e_ff;
         div_in_ff  <= div_in;
      end
   end

   // long division, nine lanes sharing one divisor
   logic         div_valid;
   div_word_type div_out;

   m3i_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (vld_ff[FRONT-1]),
      .in_word   (div_in_ff),
      .out_valid (div_valid),
      .out_word  (div_out)
   );

   // output stage: saturate, restore sign, mask singular matrices
   logic [ENTRY_W-1:0]        res_in [N_ENT];
   logic [ENTRY_W-1:0]        res_ff [N_ENT];
   logic                      singular_ff;
   logic                      overflow_in;
   logic                      overflow_ff;
   logic [QUO_W-1:0]          lim [N_ENT];
   logic [QUO_W-1:0]          mag [N_ENT];
   logic [N_ENT-1:0]          sat;

   always_comb begin
      for (int l = 0; l < N_ENT; l++) begin
         lim[l]    = div_out.lane[l].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         sat[l]    = div_out.lane[l].ovf || (div_out.lane[l].quo > lim[l]);
         mag[l]    = sat[l] ? lim[l] : div_out.lane[l].quo;
         res_in[l] = div_out.singular ? '0
                   : (div_out.lane[l].neg ? -mag[l] : mag[l]);
      end
      overflow_in = !div_out.singular && (|sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         res_ff      <= res_in;
         singular_ff <= div_out.singular;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_inv00    = $signed(res_ff[0]);
   assign rsp_inv01    = $signed(res_ff[1]);
   assign rsp_inv02    = $signed(res_ff[2]);
   assign rsp_inv10    = $signed(res_ff[3]);
   assign rsp_inv11    = $signed(res_ff[4]);
   assign rsp_inv12    = $signed(res_ff[5]);
   assign rsp_inv20    = $signed(res_ff[6]);
   assign rsp_inv21    = $signed(res_ff[7]);
   assign rsp_inv22    = $signed(res_ff[8]);
   assign rsp_singular = singular_ff;
   assign rsp_overflow = overflow_ff;

endmodule

`default_nettype wire

### hdl/m3i_div.sv
`default_nettype none

module m3i_div
   import m3i_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         enable,
   input  wire logic         in_valid,
   input  wire div_word_type in_word,
   output logic              out_valid,
   output div_word_type      out_word
);

   localparam int STAGES = QUO_W + 1;

   div_word_type word_ff [STAGES];
   logic         valid_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      div_word_type src;
      div_word_type word_in;
      logic         src_valid;

      if (s == 0) begin : g_first
         assign src       = in_word;
         assign src_valid = in_valid;

         // quotient of 2^32 or more saturates anyway
         always_comb begin
            word_in = src;
            for (int l = 0; l < N_ENT; l++) begin
               word_in.lane[l].ovf = src.lane[l].rem >= (REM_W'(src.dmag) << QUO_W);
            end
         end
      end else begin : g_bit
         localparam int SHIFT = QUO_W - s;
         logic [REM_W-1:0] sub_d;

         assign src       = word_ff[s-1];
         assign src_valid = valid_ff[s-1];
         assign sub_d     = REM_W'(src.dmag) << SHIFT;

         always_comb begin
            word_in = src;
            for (int l = 0; l < N_ENT; l++) begin
               if (src.lane[l].rem >= sub_d) begin
                  word_in.lane[l].rem        = src.lane[l].rem - sub_d;
                  word_in.lane[l].quo[SHIFT] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            word_ff[s] <= word_in;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_word  = word_ff[STAGES-1];

endmodule

`default_nettype wire

### sim/matrix3x3_inverse_tb.sv
`timescale 1ns / 1ps

// matrix inverse testbench: directed table then random matrices, checked against
// an exact 128-bit adjugate / determinant predictor

module matrix3x3_inverse_tb;
   import m3i_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 41;
   localparam int N_RANDOM = 405;

   typedef logic signed [31:0] ent_type;

   typedef struct {
      ent_type m [9];
   } mat_type;

   typedef struct {
      ent_type inv [9];
      logic singular;
      logic overflow;
   } inv_type;

   // one row of the directed table: matrix, and optionally a typed-in result
   typedef struct {
      ent_type m [9];
      bit      typed;
      inv_type res;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   ent_type req_a [9] = '{default: '0};
   logic rsp_valid;
   logic rsp_stall = 0;
   ent_type rsp_inv [9];
   logic rsp_singular, rsp_overflow;

   int   errors = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   bit   hold_off = 0;
   inv_type pending_inverses [$];
   row_type directed [$];

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   matrix3x3_inverse #(.FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a00(req_a[0]), .req_a01(req_a[1]), .req_a02(req_a[2]),
      .req_a10(req_a[3]), .req_a11(req_a[4]), .req_a12(req_a[5]),
      .req_a20(req_a[6]), .req_a21(req_a[7]), .req_a22(req_a[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_inv00(rsp_inv[0]), .rsp_inv01(rsp_inv[1]), .rsp_inv02(rsp_inv[2]),
      .rsp_inv10(rsp_inv[3]), .rsp_inv11(rsp_inv[4]), .rsp_inv12(rsp_inv[5]),
      .rsp_inv20(rsp_inv[6]), .rsp_inv21(rsp_inv[7]), .rsp_inv22(rsp_inv[8]),
      .rsp_singular(rsp_singular), .rsp_overflow(rsp_overflow)
   );

   // exact inverse: adjugate entry scaled by 2^(2F), divided by the determinant,
   // truncated toward zero and clamped to 32 bits
   function automatic inv_type invert_matrix(mat_type w);
      logic signed [127:0] a [9];
      logic signed [127:0] det, cof;
      logic [127:0] dmag, cmag, quo;
      bit neg;
      inv_type r;
      int p [9][4];
      p = '{'{4,8,5,7}, '{2,7,1,8}, '{1,5,2,4}, '{5,6,3,8}, '{0,8,2,6},
            '{2,3,0,5}, '{3,7,4,6}, '{1,6,0,7}, '{0,4,1,3}};
      foreach (a[k]) a[k] = w.m[k];
      det = a[0]*a[4]*a[8] - a[0]*a[5]*a[7] - a[1]*a[3]*a[8]
          + a[2]*a[3]*a[7] + a[1]*a[6]*a[5] - a[2]*a[6]*a[4];
      r.singular = (det == 0);
      r.overflow = 0;
      dmag = det < 0 ? -det : det;
      for (int k = 0; k < 9; k++) begin
         if (r.singular) begin
            r.inv[k] = '0;
            continue;
         end
         cof = a[p[k][0]]*a[p[k][1]] - a[p[k][2]]*a[p[k][3]];
         cmag = cof < 0 ? -cof : cof;
         quo = (cmag << (2*FRAC)) / dmag;
         neg = (cof < 0) != (det < 0);
         if (quo > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
            r.overflow = 1;
            quo = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
         end
         r.inv[k] = neg ? -quo[31:0] : quo[31:0];
      end
      return r;
   endfunction

   function automatic ent_type random_entry();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return '0;
         3, 4: return $urandom;
         5: return ent_type'($urandom_range(0, 1 << 18)) - (1 << 17);
         default: return ent_type'($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
   endfunction

   function automatic mat_type random_matrix();
      mat_type w;
      foreach (w.m[k]) w.m[k] = random_entry();
      // some rank-deficient matrices: copy one row onto another
      if ($urandom_range(0, 9) == 0)
         for (int c = 0; c < 3; c++) w.m[6 + c] = w.m[c];
      return w;
   endfunction

   // valid stays high after an accept; the next call drops it only when idling
   task automatic send_matrix(mat_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      foreach (req_a[k]) req_a[k] <= w.m[k];
      do @(posedge clock); while (req_stall);
      pending_inverses.push_back(invert_matrix(w));
   endtask

   // receiver stall, with a long hold-off window when requested
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_inverses.size() == 0) begin
            $display("%t unexpected result word", $time);
            errors++;
         end else begin
            inv_type e;
            e = pending_inverses.pop_front();
            foreach (e.inv[k])
               if (rsp_inv[k] !== e.inv[k]) begin
                  $display("%t inv[%0d] expected %h actual %h", $time, k, e.inv[k],
                           rsp_inv[k]);
                  errors++;
               end
            if (rsp_singular !== e.singular) begin
               $display("%t singular expected %b actual %b", $time, e.singular,
                        rsp_singular);
               errors++;
            end
            if (rsp_overflow !== e.overflow) begin
               $display("%t overflow expected %b actual %b", $time, e.overflow,
                        rsp_overflow);
               errors++;
            end
         end
      end
   end

   function automatic void add_row(ent_type m [9], bit typed, ent_type v, bit s, bit o);
      row_type t;
      t.m = m;
      t.typed = typed;
      foreach (t.res.inv[k]) t.res.inv[k] = (k % 4 == 0) ? v : '0;
      t.res.singular = s;
      t.res.overflow = o;
      directed.push_back(t);
   endfunction

   initial begin
      ent_type one, mx, mn;
      mat_type w;
      one = 32'sh0001_0000;
      mx = 32'sh7FFF_FFFF;
      mn = 32'sh8000_0000;
      // all zero: singular
      add_row('{0,0,0,0,0,0,0,0,0}, 1, 0, 1, 0);
      // identity inverts to identity
      add_row('{one,0,0,0,one,0,0,0,one}, 1, one, 0, 0);
      // minus identity
      add_row('{-one,0,0,0,-one,0,0,0,-one}, 1, -one, 0, 0);
      // tiny diagonal: reciprocal saturates high
      add_row('{1,0,0,0,1,0,0,0,1}, 1, mx, 0, 1);
      // tiny negative diagonal: saturates low
      add_row('{-1,0,0,0,-1,0,0,0,-1}, 1, mn, 0, 1);
      // equal rows: singular
      add_row('{mx,mn,one,mx,mn,one,3,4,5}, 1, 0, 1, 0);
      // extremes, checked by the predictor
      add_row('{mx,0,0,0,mx,0,0,0,mx}, 0, 0, 0, 0);
      add_row('{mn,0,0,0,mn,0,0,0,mn}, 0, 0, 0, 0);
      add_row('{mx,mn,mx,mn,mx,mn,mx,mx,mn}, 0, 0, 0, 0);
      add_row('{mn,mn,mx,mx,mn,mn,mn,mx,mx}, 0, 0, 0, 0);
      add_row('{-1,-1,-1,-1,mx,0,mn,1,-1}, 0, 0, 0, 0);
      add_row('{2*one,one,0,one,2*one,one,0,one,2*one}, 0, 0, 0, 0);
      add_row('{0,one,0,0,0,one,one,0,0}, 0, 0, 0, 0);
      add_row('{32'sh5555_5555,32'shAAAA_AAAA,1,7,-3,mx,mn,9,32'sh0F0F_F0F0},
              0, 0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 0;

      // directed table, no idling
      foreach (directed[i]) begin
         foreach (w.m[k]) w.m[k] = directed[i].m[k];
         send_matrix(w);
         if (directed[i].typed) begin
            // typed-in result replaces the predicted one
            pending_inverses.pop_back();
            pending_inverses.push_back(directed[i].res);
         end
      end

      // long receiver hold-off while the sender keeps offering words
      fork
         begin
            hold_off = 1;
            repeat (120) @(posedge clock);
            hold_off = 0;
         end
         repeat (80) send_matrix(random_matrix());
      join

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 79 : 0;
         recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 38 : 0;
         repeat (N_RANDOM / 3) send_matrix(random_matrix());
      end
      req_valid <= 0;
      recv_idle_pct = 0;

      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) $display("matrix3x3_inverse verification clean");
      else $display("matrix3x3_inverse verification failed");
      $finish;
   end

   initial begin
      #4ms;
      $display("matrix3x3_inverse verification failed");
      $finish;
   end

endmodule
